// File: sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// operation codes, per-stage control struct and width helpers
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   // control that travels with each transaction through the divider stages
   typedef struct packed {
      cmd_type cmd;
      logic    div_zero;
      logic    neg_re;
      logic    neg_im;
      logic    big_re;
      logic    big_im;
   } ctl_type;

   // magnitude width: sum of two full products
   function automatic int mag_width(input int w);
      return 2 * w + 1;
   endfunction

   // remainder width: holds the scaled numerator and the divisor shifted by w+1
   function automatic int rem_width(input int w, input int f);
      int a;
      int b;
      a = 2 * w + 1 + f;
      b = 3 * w + 1;
      return ((a > b) ? a : b) + 1;
   endfunction

endpackage

// File: sv/cau_mult.sv
// ----------------------------------------------------------------------------
// cau_mult: product and sum stages
// forms the four cross products and the squared divisor magnitude, then sums
// ----------------------------------------------------------------------------
module cau_mult #(
   parameter int W = cau_pkg::DATA_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  cau_pkg::cmd_type    in_cmd,
   input  logic signed [W-1:0] a_re,
   input  logic signed [W-1:0] a_im,
   input  logic signed [W-1:0] b_re,
   input  logic signed [W-1:0] b_im,
   output logic                sum_valid,
   output cau_pkg::cmd_type    sum_cmd,
   output logic signed [2*W:0] sum_re,
   output logic signed [2*W:0] sum_im,
   output logic [2*W-1:0]      sum_den
);

   logic signed [2*W-1:0] m_rr, m_ii, m_ri, m_ir, m_bb_r, m_bb_i;
   logic signed [2*W-1:0] x_ar, x_ai, x_br, x_bi;

   logic                  p_valid_ff;
   cau_pkg::cmd_type      p_cmd_ff;
   logic signed [2*W-1:0] t_re0_in, t_re1_in, t_im0_in, t_im1_in;
   logic signed [2*W-1:0] t_re0_ff, t_re1_ff, t_im0_ff, t_im1_ff;
   logic [2*W-1:0]        d0_ff, d1_ff;

   logic                  s_valid_ff;
   cau_pkg::cmd_type      s_cmd_ff;
   logic signed [2*W:0]   s_re_in, s_im_in, s_re_ff, s_im_ff;
   logic [2*W-1:0]        den_in, den_ff;

   assign m_rr   = a_re * b_re;
   assign m_ii   = a_im * b_im;
   assign m_ri   = a_re * b_im;
   assign m_ir   = a_im * b_re;
   assign m_bb_r = b_re * b_re;
   assign m_bb_i = b_im * b_im;

   assign x_ar = {{W{a_re[W-1]}}, a_re};
   assign x_ai = {{W{a_im[W-1]}}, a_im};
   assign x_br = {{W{b_re[W-1]}}, b_re};
   assign x_bi = {{W{b_im[W-1]}}, b_im};

   // pick the two terms of each part
   always_comb begin
      case (in_cmd)
         cau_pkg::CMD_ADD: begin
            t_re0_in = x_ar;  t_re1_in = x_br;
            t_im0_in = x_ai;  t_im1_in = x_bi;
         end
         cau_pkg::CMD_SUB: begin
            t_re0_in = x_ar;  t_re1_in = -x_br;
            t_im0_in = x_ai;  t_im1_in = -x_bi;
         end
         cau_pkg::CMD_MUL: begin
            t_re0_in = m_rr;  t_re1_in = -m_ii;
            t_im0_in = m_ri;  t_im1_in = m_ir;
         end
         default: begin
            t_re0_in = m_rr;  t_re1_in = m_ii;
            t_im0_in = m_ir;  t_im1_in = -m_ri;
         end
      endcase
   end

   assign s_re_in = {t_re0_ff[2*W-1], t_re0_ff} + {t_re1_ff[2*W-1], t_re1_ff};
   assign s_im_in = {t_im0_ff[2*W-1], t_im0_ff} + {t_im1_ff[2*W-1], t_im1_ff};
   assign den_in  = d0_ff + d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= in_valid;
         s_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_cmd_ff <= in_cmd;
         t_re0_ff <= t_re0_in;
         t_re1_ff <= t_re1_in;
         t_im0_ff <= t_im0_in;
         t_im1_ff <= t_im1_in;
         d0_ff    <= m_bb_r;
         d1_ff    <= m_bb_i;
         s_cmd_ff <= p_cmd_ff;
         s_re_ff  <= s_re_in;
         s_im_ff  <= s_im_in;
         den_ff   <= den_in;
      end
   end

   assign sum_valid = s_valid_ff;
   assign sum_cmd   = s_cmd_ff;
   assign sum_re    = s_re_ff;
   assign sum_im    = s_im_ff;
   assign sum_den   = den_ff;

endmodule

// File: sv/cau_norm.sv
// ----------------------------------------------------------------------------
// cau_norm: sign/magnitude stage
// splits each part into sign and magnitude, scales numerators, flags zero
// divisors and quotients too large to represent
// ----------------------------------------------------------------------------
module cau_norm #(
   parameter int W = cau_pkg::DATA_WIDTH_DEF,
   parameter int F = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  cau_pkg::cmd_type                         in_cmd,
   input  logic signed [2*W:0]                      in_re,
   input  logic signed [2*W:0]                      in_im,
   input  logic [2*W-1:0]                           in_den,
   output logic                                     out_valid,
   output cau_pkg::ctl_type                         out_ctl,
   output logic [cau_pkg::rem_width(W, F)-1:0]      out_r_re,
   output logic [cau_pkg::rem_width(W, F)-1:0]      out_r_im,
   output logic [cau_pkg::mag_width(W)-1:0]         out_mag_re,
   output logic [cau_pkg::mag_width(W)-1:0]         out_mag_im,
   output logic [2*W-1:0]                           out_den
);

   localparam int MW = cau_pkg::mag_width(W);
   localparam int RW = cau_pkg::rem_width(W, F);

   logic [MW-1:0]    mag_re, mag_im;
   logic [RW-1:0]    num_re, num_im, den_top;
   cau_pkg::ctl_type ctl_in;

   logic             valid_ff;
   cau_pkg::ctl_type ctl_ff;
   logic [RW-1:0]    r_re_ff, r_im_ff;
   logic [MW-1:0]    mag_re_ff, mag_im_ff;
   logic [2*W-1:0]   den_ff;

   assign mag_re  = in_re[2*W] ? MW'(-in_re) : MW'(in_re);
   assign mag_im  = in_im[2*W] ? MW'(-in_im) : MW'(in_im);
   assign num_re  = RW'(mag_re) << F;
   assign num_im  = RW'(mag_im) << F;
   assign den_top = RW'(in_den) << (W + 1);

   always_comb begin
      ctl_in.cmd      = in_cmd;
      ctl_in.div_zero = (in_cmd == cau_pkg::CMD_DIV) && (in_den == '0);
      ctl_in.neg_re   = in_re[2*W];
      ctl_in.neg_im   = in_im[2*W];
      ctl_in.big_re   = num_re >= den_top;
      ctl_in.big_im   = num_im >= den_top;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff    <= ctl_in;
         r_re_ff   <= num_re;
         r_im_ff   <= num_im;
         mag_re_ff <= mag_re;
         mag_im_ff <= mag_im;
         den_ff    <= in_den;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_r_re   = r_re_ff;
   assign out_r_im   = r_im_ff;
   assign out_mag_re = mag_re_ff;
   assign out_mag_im = mag_im_ff;
   assign out_den    = den_ff;

endmodule

// File: sv/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step: one restoring division stage
// resolves quotient bit SHIFT of both parts against the shared divisor
// ----------------------------------------------------------------------------
module cau_div_step #(
   parameter int W     = cau_pkg::DATA_WIDTH_DEF,
   parameter int F     = cau_pkg::FRAC_BITS_DEF,
   parameter int SHIFT = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  cau_pkg::ctl_type                    in_ctl,
   input  logic [cau_pkg::rem_width(W, F)-1:0] in_r_re,
   input  logic [cau_pkg::rem_width(W, F)-1:0] in_r_im,
   input  logic [W:0]                          in_q_re,
   input  logic [W:0]                          in_q_im,
   input  logic [cau_pkg::mag_width(W)-1:0]    in_mag_re,
   input  logic [cau_pkg::mag_width(W)-1:0]    in_mag_im,
   input  logic [2*W-1:0]                      in_den,
   output logic                                out_valid,
   output cau_pkg::ctl_type                    out_ctl,
   output logic [cau_pkg::rem_width(W, F)-1:0] out_r_re,
   output logic [cau_pkg::rem_width(W, F)-1:0] out_r_im,
   output logic [W:0]                          out_q_re,
   output logic [W:0]                          out_q_im,
   output logic [cau_pkg::mag_width(W)-1:0]    out_mag_re,
   output logic [cau_pkg::mag_width(W)-1:0]    out_mag_im,
   output logic [2*W-1:0]                      out_den
);

   localparam int MW = cau_pkg::mag_width(W);
   localparam int RW = cau_pkg::rem_width(W, F);

   logic [RW-1:0]    d_sh;
   logic             ge_re, ge_im;
   logic [W:0]       q_bit;

   logic             valid_ff;
   cau_pkg::ctl_type ctl_ff;
   logic [RW-1:0]    r_re_ff, r_im_ff;
   logic [W:0]       q_re_ff, q_im_ff;
   logic [MW-1:0]    mag_re_ff, mag_im_ff;
   logic [2*W-1:0]   den_ff;

   assign d_sh  = RW'(in_den) << SHIFT;
   assign ge_re = in_r_re >= d_sh;
   assign ge_im = in_r_im >= d_sh;
   assign q_bit = (W + 1)'(1) << SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff    <= in_ctl;
         r_re_ff   <= ge_re ? (in_r_re - d_sh) : in_r_re;
         r_im_ff   <= ge_im ? (in_r_im - d_sh) : in_r_im;
         q_re_ff   <= ge_re ? (in_q_re | q_bit) : in_q_re;
         q_im_ff   <= ge_im ? (in_q_im | q_bit) : in_q_im;
         mag_re_ff <= in_mag_re;
         mag_im_ff <= in_mag_im;
         den_ff    <= in_den;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_r_re   = r_re_ff;
   assign out_r_im   = r_im_ff;
   assign out_q_re   = q_re_ff;
   assign out_q_im   = q_im_ff;
   assign out_mag_re = mag_re_ff;
   assign out_mag_im = mag_im_ff;
   assign out_den    = den_ff;

endmodule

// File: sv/cau_sat.sv
// ----------------------------------------------------------------------------
// cau_sat: result select and saturation stage
// picks the magnitude per operation, saturates, drives the output register
// ----------------------------------------------------------------------------
module cau_sat #(
   parameter int W = cau_pkg::DATA_WIDTH_DEF,
   parameter int F = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  cau_pkg::ctl_type                 in_ctl,
   input  logic [W:0]                       in_q_re,
   input  logic [W:0]                       in_q_im,
   input  logic [cau_pkg::mag_width(W)-1:0] in_mag_re,
   input  logic [cau_pkg::mag_width(W)-1:0] in_mag_im,
   output logic                             out_valid,
   output logic signed [W-1:0]              out_re,
   output logic signed [W-1:0]              out_im,
   output logic                             out_overflow,
   output logic                             out_div_zero
);

   localparam int MW = cau_pkg::mag_width(W);
   localparam logic [MW-1:0] POS_MAX = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
   localparam logic [MW-1:0] NEG_MAG = POS_MAX + MW'(1);
   localparam logic [MW-1:0] CAP     = MW'(1) << W;

   logic [MW-1:0]       sel_re, sel_im;
   logic [W:0]          sat_re, sat_im;

   logic                valid_ff;
   logic signed [W-1:0] re_ff, im_ff;
   logic                ovf_ff, dz_ff;

   // returns {overflow, value}
   function automatic logic [W:0] saturate(input logic neg, input logic [MW-1:0] m);
      logic [MW-1:0] neg_m;
      neg_m = '0 - m;
      if (!neg) begin
         saturate = (m > POS_MAX) ? {1'b1, POS_MAX[W-1:0]} : {1'b0, m[W-1:0]};
      end else begin
         saturate = (m > NEG_MAG) ? {1'b1, 1'b1, {(W - 1){1'b0}}}
                                  : {1'b0, neg_m[W-1:0]};
      end
   endfunction

   always_comb begin
      case (in_ctl.cmd)
         cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
            sel_re = in_mag_re;
            sel_im = in_mag_im;
         end
         cau_pkg::CMD_MUL: begin
            sel_re = in_mag_re >> F;
            sel_im = in_mag_im >> F;
         end
         default: begin
            sel_re = in_ctl.big_re ? CAP : MW'(in_q_re);
            sel_im = in_ctl.big_im ? CAP : MW'(in_q_im);
         end
      endcase
   end

   assign sat_re = saturate(in_ctl.neg_re, sel_re);
   assign sat_im = saturate(in_ctl.neg_im, sel_im);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (in_ctl.div_zero) begin
            re_ff  <= '0;
            im_ff  <= '0;
            ovf_ff <= 1'b0;
         end else begin
            re_ff  <= sat_re[W-1:0];
            im_ff  <= sat_im[W-1:0];
            ovf_ff <= sat_re[W] | sat_im[W];
         end
         dz_ff <= in_ctl.div_zero;
      end
   end

   assign out_valid    = valid_ff;
   assign out_re       = re_ff;
   assign out_im       = im_ff;
   assign out_overflow = ovf_ff;
   assign out_div_zero = dz_ff;

endmodule

// File: sv/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add/sub/mul/div in signed fixed point
// Usage:
//   req_* carries one transaction: operation code and operands A and B, taken
//   when req_valid is high and req_stall is low.
//   rsp_* returns one transaction per request, in order: result parts,
//   overflow (a part saturated) and div_zero (divide by zero, result zero).
//   Throughput: one transaction per cycle while rsp_stall stays low.
//   Stages: two product and sum stages, one sign/magnitude stage,
//   DATA_WIDTH + 1 restoring division stages (one quotient bit each),
//   and the saturating output register.
//   All operations run through the full pipeline so order and latency match.
//   A stalled result holds the whole pipeline; req_stall rises in the same
//   cycle, so nothing is lost or repeated.
//   Reset clears every stage's valid bit; no transaction is in flight after.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_a_re,
   input  logic signed [DATA_WIDTH-1:0] req_a_im,
   input  logic signed [DATA_WIDTH-1:0] req_b_re,
   input  logic signed [DATA_WIDTH-1:0] req_b_im,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_res_re,
   output logic signed [DATA_WIDTH-1:0] rsp_res_im,
   output logic                         rsp_overflow,
   output logic                         rsp_div_zero
);

   localparam int W  = DATA_WIDTH;
   localparam int MW = cau_pkg::mag_width(W);
   localparam int RW = cau_pkg::rem_width(W, FRAC_BITS);
   localparam int NS = W + 1;   // division stages

   // whole pipeline moves unless a finished result is being held
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // product and sum stages
   logic                sum_valid;
   cau_pkg::cmd_type    sum_cmd;
   logic signed [2*W:0] sum_re, sum_im;
   logic [2*W-1:0]      sum_den;

   cau_mult #(.W(W)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_cmd    (cau_pkg::cmd_type'(req_cmd)),
      .a_re      (req_a_re),
      .a_im      (req_a_im),
      .b_re      (req_b_re),
      .b_im      (req_b_im),
      .sum_valid (sum_valid),
      .sum_cmd   (sum_cmd),
      .sum_re    (sum_re),
      .sum_im    (sum_im),
      .sum_den   (sum_den)
   );

   // division chain taps: entry 0 from the sign/magnitude stage
   logic             st_valid  [0:NS];
   cau_pkg::ctl_type st_ctl    [0:NS];
   logic [RW-1:0]    st_r_re   [0:NS];
   logic [RW-1:0]    st_r_im   [0:NS];
   logic [W:0]       st_q_re   [0:NS];
   logic [W:0]       st_q_im   [0:NS];
   logic [MW-1:0]    st_mag_re [0:NS];
   logic [MW-1:0]    st_mag_im [0:NS];
   logic [2*W-1:0]   st_den    [0:NS];

   cau_norm #(.W(W), .F(FRAC_BITS)) u_norm (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (sum_valid),
      .in_cmd     (sum_cmd),
      .in_re      (sum_re),
      .in_im      (sum_im),
      .in_den     (sum_den),
      .out_valid  (st_valid[0]),
      .out_ctl    (st_ctl[0]),
      .out_r_re   (st_r_re[0]),
      .out_r_im   (st_r_im[0]),
      .out_mag_re (st_mag_re[0]),
      .out_mag_im (st_mag_im[0]),
      .out_den    (st_den[0])
   );

   // quotient starts empty
   assign st_q_re[0] = '0;
   assign st_q_im[0] = '0;

   // most significant quotient bit first
   for (genvar i = 0; i < NS; i++) begin : g_div
      cau_div_step #(.W(W), .F(FRAC_BITS), .SHIFT(W - i)) u_step (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .in_valid   (st_valid[i]),
         .in_ctl     (st_ctl[i]),
         .in_r_re    (st_r_re[i]),
         .in_r_im    (st_r_im[i]),
         .in_q_re    (st_q_re[i]),
         .in_q_im    (st_q_im[i]),
         .in_mag_re  (st_mag_re[i]),
         .in_mag_im  (st_mag_im[i]),
         .in_den     (st_den[i]),
         .out_valid  (st_valid[i+1]),
         .out_ctl    (st_ctl[i+1]),
         .out_r_re   (st_r_re[i+1]),
         .out_r_im   (st_r_im[i+1]),
         .out_q_re   (st_q_re[i+1]),
         .out_q_im   (st_q_im[i+1]),
         .out_mag_re (st_mag_re[i+1]),
         .out_mag_im (st_mag_im[i+1]),
         .out_den    (st_den[i+1])
      );
   end

   // final remainder and divisor are only needed inside the chain
   logic unused_tail;
   assign unused_tail = ^{st_r_re[NS], st_r_im[NS], st_den[NS]};

   // select, saturate and hold the result
   cau_sat #(.W(W), .F(FRAC_BITS)) u_sat (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (st_valid[NS]),
      .in_ctl       (st_ctl[NS]),
      .in_q_re      (st_q_re[NS]),
      .in_q_im      (st_q_im[NS]),
      .in_mag_re    (st_mag_re[NS] ^ {MW{1'b0 & unused_tail}}),
      .in_mag_im    (st_mag_im[NS]),
      .out_valid    (rsp_valid),
      .out_re       (rsp_res_re),
      .out_im       (rsp_res_im),
      .out_overflow (rsp_overflow),
      .out_div_zero (rsp_div_zero)
   );

`ifndef SYNTH
   // a held result must block new transactions
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("transaction accepted while result held");

   // divide by zero returns zero with no overflow
   a_div_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (rsp_res_re == '0 && rsp_res_im == '0 && !rsp_overflow))
      else $error("divide by zero result not zero");

   // overflow means at least one part sits at a range limit
   a_overflow_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_res_re == {1'b0, {(W - 1){1'b1}}} || rsp_res_re == {1'b1, {(W - 1){1'b0}}} ||
          rsp_res_im == {1'b0, {(W - 1){1'b1}}} || rsp_res_im == {1'b1, {(W - 1){1'b0}}}))
      else $error("overflow flagged without saturated part");

   // a stalled pipeline keeps the division stage entry in place
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!adv) |=> (st_valid[0] == $past(st_valid[0])))
      else $error("pipeline moved while stalled");
`endif

endmodule
